[rtl/core/assert_macros.svh]
// Assertion macros used by the checker module of this block.
// Each macro takes a label, a clock, an active-low reset, the condition
// pair and a message for the failure report.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`define ASSERT_AFTER4(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##4 (cons)) \
    else $error(msg);

`endif

[rtl/core/vlo_pkg.sv]
// ---------------------------------------------------------------------------
// vlo_pkg
// Types, register codes, geometry constants and the evidence table of the
// voxel log-odds occupancy update.
// ---------------------------------------------------------------------------
package vlo_pkg;

  // Grid geometry.
  localparam int AXIS_CELLS = 64;
  localparam int AXIS_BITS  = $clog2(AXIS_CELLS);
  localparam int VOXEL_AW   = 3 * AXIS_BITS;
  localparam int SLICE_AW   = 2 * AXIS_BITS;

  // Fixed-point widths.
  localparam int COORD_W = 24;
  localparam int INV_W   = 16;
  localparam int HALF_W  = 23;
  localparam int LO_W    = 16;
  localparam int CODE_W  = 8;
  localparam int SUM_W   = COORD_W + 1;
  localparam int PROD_W  = SUM_W + INV_W + 1;
  localparam int IDX_LSB = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_INV_VOXEL_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LO_FLOOR       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LO_CEILING     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_HIGH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_THRESHOLD  = 3'd6;

  // Input item.
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [CODE_W-1:0]         hit_prob_code;
  } vlo_in_t;

  // Result item.
  typedef struct packed {
    logic                   in_bounds;
    logic [AXIS_BITS-1:0]   voxel_x;
    logic [AXIS_BITS-1:0]   voxel_y;
    logic [AXIS_BITS-1:0]   voxel_z;
    logic signed [LO_W-1:0] voxel_value;
    logic                   occupied;
    logic                   slice_updated;
    logic signed [LO_W-1:0] slice_value;
  } vlo_out_t;

  // Control from the update sequencer to the store.
  typedef struct packed {
    logic rd_en;
    logic wr_voxel;
    logic wr_slice;
  } vlo_store_ctrl_t;

  typedef logic signed [LO_W-1:0] evidence_rom_t [0:(1 << CODE_W)-1];

  // One evidence entry: round(256 * ln((2q+1) / (511-2q))), half away from zero.
  function automatic logic signed [LO_W-1:0] evidence_of(int q);
    real d;
    real r;
    int  m;
    d = $ln(2.0 * q + 1.0) - $ln(511.0 - 2.0 * q);
    r = 256.0 * d;
    if (r >= 0.0) begin
      m = $rtoi(r + 0.5);
    end else begin
      m = -$rtoi(0.5 - r);
    end
    return LO_W'(m);
  endfunction

  // Whole evidence table, built at elaboration.
  function automatic evidence_rom_t build_evidence();
    evidence_rom_t t;
    for (int q = 0; q < (1 << CODE_W); q++) begin
      t[q] = evidence_of(q);
    end
    return t;
  endfunction

  localparam evidence_rom_t EVIDENCE_ROM = build_evidence();

endpackage

[rtl/core/vlo_store.sv]
// ---------------------------------------------------------------------------
// vlo_store
// Voxel and slice log-odds memories with registered reads, a
// single write port each, and a zeroing sweep after reset.
// ---------------------------------------------------------------------------
module vlo_store import vlo_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  vlo_store_ctrl_t        ctrl_i,
  input  logic [VOXEL_AW-1:0]    voxel_addr_i,
  input  logic [SLICE_AW-1:0]    slice_addr_i,
  input  logic signed [LO_W-1:0] voxel_wdata_i,
  input  logic signed [LO_W-1:0] slice_wdata_i,
  output logic signed [LO_W-1:0] voxel_rdata_o,
  output logic signed [LO_W-1:0] slice_rdata_o,
  output logic                   clearing_o
);

  logic signed [LO_W-1:0] voxel_mem [0:(1 << VOXEL_AW)-1];
  logic signed [LO_W-1:0] slice_mem [0:(1 << SLICE_AW)-1];

  logic                clearing_q, clearing_d;
  logic [VOXEL_AW-1:0] clr_addr_q, clr_addr_d;

  logic                   vox_we, slc_we;
  logic [VOXEL_AW-1:0]    vox_waddr;
  logic [SLICE_AW-1:0]    slc_waddr;
  logic signed [LO_W-1:0] vox_wdata, slc_wdata;

  // Clearing sweep: one voxel entry per cycle; the slice is covered on the way.
  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Write port selection between the sweep and the update.
  always_comb begin
    if (clearing_q) begin
      vox_we    = 1'b1;
      slc_we    = 1'b1;
      vox_waddr = clr_addr_q;
      slc_waddr = clr_addr_q[SLICE_AW-1:0];
      vox_wdata = '0;
      slc_wdata = '0;
    end else begin
      vox_we    = ctrl_i.wr_voxel;
      slc_we    = ctrl_i.wr_slice;
      vox_waddr = voxel_addr_i;
      slc_waddr = slice_addr_i;
      vox_wdata = voxel_wdata_i;
      slc_wdata = slice_wdata_i;
    end
  end

  // Voxel memory.
  always_ff @(posedge clk_i) begin
    if (vox_we) begin
      voxel_mem[vox_waddr] <= vox_wdata;
    end
    if (ctrl_i.rd_en) begin
      voxel_rdata_o <= voxel_mem[voxel_addr_i];
    end
  end

  // Slice memory.
  always_ff @(posedge clk_i) begin
    if (slc_we) begin
      slice_mem[slc_waddr] <= slc_wdata;
    end
    if (ctrl_i.rd_en) begin
      slice_rdata_o <= slice_mem[slice_addr_i];
    end
  end

  assign clearing_o = clearing_q;

endmodule

[rtl/core/voxel_log_odds_occupancy_update.sv]
// An accepted item goes through the index multiply, the memory read, the
// read-modify-write of the log-odds entries and the result register in turn, which
// raises the result strobe. One item is worked at a time: a new item is taken only
// once the last has left the read-modify-write. After reset both stores are zeroed
// by a sweep of the 262144 voxel entries, during which busy is high; configuration
// writes are taken at any time. The receiver cannot stall.
// ---------------------------------------------------------------------------
// voxel_log_odds_occupancy_update
// Maps a point to its voxel and, when it lies in the grid, adds the evidence for its
// hit probability to the stored log-odds with clamping, and does the same for the 2D
// slice cell when the point's height also lies in the depth band.
// ---------------------------------------------------------------------------
module voxel_log_odds_occupancy_update import vlo_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  vlo_in_t               item_i,
  output logic                  result_valid_o,
  output vlo_out_t              result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  // Configuration registers.
  logic [INV_W-1:0]          inv_q;
  logic [HALF_W-1:0]         half_q;
  logic signed [LO_W-1:0]    floor_q, ceil_q, thr_q;
  logic signed [COORD_W-1:0] dlow_q, dhigh_q;

  logic [1:0]                state_q, state_d;
  logic                      valid_q, valid_d;
  vlo_in_t                   item_q;
  logic [AXIS_BITS-1:0]      ix_q, iy_q, iz_q;
  logic                      inb_q, band_q;
  logic signed [LO_W-1:0]    ev_q;
  vlo_out_t                  res_q, res_d;

  logic [AXIS_BITS:0]        map_x, map_y, map_z;
  logic                      clearing;
  vlo_store_ctrl_t           st_ctrl;
  logic signed [LO_W-1:0]    vox_rd, slc_rd, vox_new, slc_new;

  // Voxel index on one axis: {in range, index}.
  function automatic logic [AXIS_BITS:0] axis_map(logic signed [COORD_W-1:0] c,
                                                  logic [HALF_W-1:0] h,
                                                  logic [INV_W-1:0] inv);
    logic signed [SUM_W-1:0]  s;
    logic signed [PROD_W-1:0] p;
    logic                     ok;
    s  = SUM_W'(c) + $signed({{(SUM_W - HALF_W){1'b0}}, h});
    p  = PROD_W'(s) * $signed({{(PROD_W - INV_W){1'b0}}, inv});
    ok = (p[PROD_W-1:IDX_LSB+AXIS_BITS] == '0);
    return {ok, p[IDX_LSB+AXIS_BITS-1:IDX_LSB]};
  endfunction

  // Add evidence and clamp, floor first and then ceiling.
  function automatic logic signed [LO_W-1:0] clamp_add(logic signed [LO_W-1:0] v,
                                                       logic signed [LO_W-1:0] e,
                                                       logic signed [LO_W-1:0] lo,
                                                       logic signed [LO_W-1:0] hi);
    logic signed [LO_W:0] s;
    s = (LO_W+1)'(v) + (LO_W+1)'(e);
    if (s < (LO_W+1)'(lo)) begin
      s = (LO_W+1)'(lo);
    end
    if (s > (LO_W+1)'(hi)) begin
      s = (LO_W+1)'(hi);
    end
    return s[LO_W-1:0];
  endfunction

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q   <= INV_W'(256);
      half_q  <= HALF_W'(12800);
      floor_q <= -LO_W'(1280);
      ceil_q  <= LO_W'(1280);
      dlow_q  <= -COORD_W'(256);
      dhigh_q <= COORD_W'(256);
      thr_q   <= -LO_W'(562);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INV_VOXEL_SIZE: inv_q   <= cfg_wdata_i[INV_W-1:0];
        REG_HALF_EXTENT:    half_q  <= cfg_wdata_i[HALF_W-1:0];
        REG_LO_FLOOR:       floor_q <= cfg_wdata_i[LO_W-1:0];
        REG_LO_CEILING:     ceil_q  <= cfg_wdata_i[LO_W-1:0];
        REG_DEPTH_LOW:      dlow_q  <= cfg_wdata_i[COORD_W-1:0];
        REG_DEPTH_HIGH:     dhigh_q <= cfg_wdata_i[COORD_W-1:0];
        REG_OCC_THRESHOLD:  thr_q   <= cfg_wdata_i[LO_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = clearing || (state_q != ST_IDLE);

  // Index mapping of the held item.
  assign map_x = axis_map(item_q.point_x, half_q, inv_q);
  assign map_y = axis_map(item_q.point_y, half_q, inv_q);
  assign map_z = axis_map(item_q.point_z, half_q, inv_q);

  // Clamped updates from the read data.
  assign vox_new = clamp_add(vox_rd, ev_q, floor_q, ceil_q);
  assign slc_new = clamp_add(slc_rd, ev_q, floor_q, ceil_q);

  // Sequencer and store control.
  always_comb begin
    state_d          = state_q;
    valid_d          = 1'b0;
    res_d            = res_q;
    st_ctrl.rd_en    = 1'b0;
    st_ctrl.wr_voxel = 1'b0;
    st_ctrl.wr_slice = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start && !busy) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_READ;
      end
      ST_READ: begin
        st_ctrl.rd_en = 1'b1;
        state_d       = ST_UPD;
      end
      ST_UPD: begin
        st_ctrl.wr_voxel = inb_q;
        st_ctrl.wr_slice = inb_q && band_q;
        valid_d          = 1'b1;
        res_d            = '0;
        if (inb_q) begin
          res_d.in_bounds   = 1'b1;
          res_d.voxel_x     = ix_q;
          res_d.voxel_y     = iy_q;
          res_d.voxel_z     = iz_q;
          res_d.voxel_value = vox_new;
          res_d.occupied    = (vox_new >= thr_q);
          if (band_q) begin
            res_d.slice_updated = 1'b1;
            res_d.slice_value   = slc_new;
          end
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // Item, index and result registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start && !busy) begin
      item_q <= item_i;
    end
    if (state_q == ST_MUL) begin
      ix_q   <= map_x[AXIS_BITS-1:0];
      iy_q   <= map_y[AXIS_BITS-1:0];
      iz_q   <= map_z[AXIS_BITS-1:0];
      inb_q  <= map_x[AXIS_BITS] && map_y[AXIS_BITS] && map_z[AXIS_BITS];
      band_q <= (item_q.point_z >= dlow_q) && (item_q.point_z <= dhigh_q);
      ev_q   <= EVIDENCE_ROM[item_q.hit_prob_code];
    end
    res_q <= res_d;
  end

  vlo_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (st_ctrl),
    .voxel_addr_i  ({iz_q, iy_q, ix_q}),
    .slice_addr_i  ({iy_q, ix_q}),
    .voxel_wdata_i (vox_new),
    .slice_wdata_i (slc_new),
    .voxel_rdata_o (vox_rd),
    .slice_rdata_o (slc_rd),
    .clearing_o    (clearing)
  );

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

[rtl/core/vlo_checker.sv]
// ---------------------------------------------------------------------------
// vlo_checker
// Port-level checks of the occupancy update: result timing against accepted
// items and the zero fields of dropped points and skipped slice updates.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vlo_checker import vlo_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     result_valid_o,
  input vlo_out_t result_o
);

  // Every accepted item is followed by its result strobe.
  `ASSERT_AFTER4(a_result_latency, clk_i, rst_ni, start && !busy, result_valid_o, "missing result")

  // A result is shown for one cycle only, as one item is worked at a time.
  `ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, result_valid_o, !result_valid_o, "repeated result")

  // A dropped point reports zero in every field.
  `ASSERT_SAME(a_drop_zero, clk_i, rst_ni, result_valid_o && !result_o.in_bounds, result_o == '0, "dropped point has non-zero fields")

  // A skipped slice update reports a zero slice value.
  `ASSERT_SAME(a_slice_zero, clk_i, rst_ni, result_valid_o && !result_o.slice_updated, result_o.slice_value == '0, "slice value without update")

endmodule

bind voxel_log_odds_occupancy_update vlo_checker u_vlo_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
